[hdl/pit_pkg.sv]
// Shared types and constants for the periodic interrupt timer.
`default_nettype none

package pit_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int OUT_BITS   = 4;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    REG_LOAD   = 3'd0,
    REG_COUNT  = 3'd1,
    REG_CTRL   = 3'd2,
    REG_FLAG   = 3'd3,
    REG_MODULE = 3'd4
  } reg_sel_t;

  typedef struct packed {
    logic tick;
    logic load_wr;
    logic ctrl_wr;
    logic flag_clr;
  } chan_ctrl_t;

  typedef struct packed {
    logic irq;
    logic fired;
  } chan_stat_t;

endpackage

`default_nettype wire

[hdl/pit_channel.sv]
// One timer channel: load value, down-counter, enables and expiry flag.
`default_nettype none

module pit_channel import pit_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire chan_ctrl_t            ctrl,
  input  wire logic [DATA_WIDTH-1:0] write_data,
  input  wire logic [2:0]            register_select,
  output      chan_stat_t            stat,
  output      logic [DATA_WIDTH-1:0] read_data
);

  logic [COUNT_WIDTH-1:0] load_value, load_value_next;
  logic [COUNT_WIDTH-1:0] down_count, down_count_next;
  logic                   timer_enable, timer_enable_next;
  logic                   irq_enable, irq_enable_next;
  logic                   expiry_flag, expiry_flag_next;
  logic                   fired;

  always_comb begin
    load_value_next   = load_value;
    down_count_next   = down_count;
    timer_enable_next = timer_enable;
    irq_enable_next   = irq_enable;
    expiry_flag_next  = expiry_flag;
    fired             = 1'b0;
    if (ctrl.tick && timer_enable) begin
      if (down_count == '0) begin
        down_count_next  = load_value;
        expiry_flag_next = 1'b1;
        fired            = 1'b1;
      end else begin
        down_count_next = down_count - COUNT_WIDTH'(1);
      end
    end
    if (ctrl.load_wr) begin
      load_value_next = write_data[COUNT_WIDTH-1:0];
    end
    if (ctrl.ctrl_wr) begin
      if (write_data[0] && !timer_enable) begin
        down_count_next = load_value;
      end
      timer_enable_next = write_data[0];
      irq_enable_next   = write_data[1];
    end
    if (ctrl.flag_clr) begin
      expiry_flag_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_value   <= '0;
      down_count   <= '0;
      timer_enable <= 1'b0;
      irq_enable   <= 1'b0;
      expiry_flag  <= 1'b0;
    end else begin
      load_value   <= load_value_next;
      down_count   <= down_count_next;
      timer_enable <= timer_enable_next;
      irq_enable   <= irq_enable_next;
      expiry_flag  <= expiry_flag_next;
    end
  end

  always_comb begin
    stat.irq   = expiry_flag_next && irq_enable_next;
    stat.fired = fired;
  end

  always_comb begin
    case (register_select)
      REG_LOAD:  read_data = DATA_WIDTH'(load_value);
      REG_COUNT: read_data = DATA_WIDTH'(down_count);
      REG_CTRL:  read_data = DATA_WIDTH'({irq_enable, timer_enable});
      REG_FLAG:  read_data = DATA_WIDTH'(expiry_flag);
      default:   read_data = '0;
    endcase
  end

endmodule

`default_nettype wire

[hdl/periodic_interrupt_timer_top.sv]
// Top level of the periodic interrupt timer: input register, channels and result register.
//
// The timer takes one item per clock cycle while the output is not stalled. An item is
// held in an input register and acts on the channel state at the edge at which it
// leaves that register; its result is captured in the output register at that same
// edge. While the output is stalled the item waits in the input register. The next
// item sees the state left by the previous one. Each item gives exactly one result;
// the module comes out of reset with the module disable bit set, so ticks change
// nothing until it is cleared through the module control register.
`default_nettype none

module periodic_interrupt_timer_top import pit_pkg::*; #(
  parameter int CHANNELS    = 4,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire logic [1:0]            command,
  input  wire logic [1:0]            channel,
  input  wire logic [2:0]            register_select,
  input  wire logic [DATA_WIDTH-1:0] write_data,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      logic [DATA_WIDTH-1:0] read_data,
  output      logic [OUT_BITS-1:0]   irq_lines,
  output      logic [OUT_BITS-1:0]   expired_now
);

  logic                  s1_valid;
  logic [1:0]            s1_command;
  logic [1:0]            s1_channel;
  logic [2:0]            s1_sel;
  logic [DATA_WIDTH-1:0] s1_data;
  logic                  module_disable, module_disable_next;
  logic                  advance;
  logic                  go;

  chan_ctrl_t            ctrl     [CHANNELS];
  chan_stat_t            stat     [CHANNELS];
  logic [DATA_WIDTH-1:0] chan_rd  [CHANNELS];

  logic [DATA_WIDTH-1:0] rd_value;
  logic [OUT_BITS-1:0]   irq_value;
  logic [OUT_BITS-1:0]   fired_value;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign go       = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_command <= command;
      s1_channel <= channel;
      s1_sel     <= register_select;
      s1_data    <= write_data;
    end
  end

  always_comb begin
    module_disable_next = module_disable;
    if (go && s1_command == CMD_WRITE && s1_sel == REG_MODULE) begin
      module_disable_next = s1_data[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      module_disable <= 1'b1;
    end else begin
      module_disable <= module_disable_next;
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    logic hit;
    logic wr;

    assign hit = ({1'b0, s1_channel} == 3'(c));
    assign wr  = go && s1_command == CMD_WRITE && hit;

    always_comb begin
      ctrl[c].tick     = go && s1_command == CMD_TICK && !module_disable;
      ctrl[c].load_wr  = wr && s1_sel == REG_LOAD;
      ctrl[c].ctrl_wr  = wr && s1_sel == REG_CTRL;
      ctrl[c].flag_clr = wr && s1_sel == REG_FLAG && s1_data[0];
    end

    pit_channel #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_channel (
      .clk             (clk),
      .rst             (rst),
      .ctrl            (ctrl[c]),
      .write_data      (s1_data),
      .register_select (s1_sel),
      .stat            (stat[c]),
      .read_data       (chan_rd[c])
    );
  end

  for (genvar b = 0; b < OUT_BITS; b++) begin : g_bits
    if (b < CHANNELS) begin : g_used
      assign irq_value[b]   = stat[b].irq;
      assign fired_value[b] = stat[b].fired;
    end else begin : g_unused
      assign irq_value[b]   = 1'b0;
      assign fired_value[b] = 1'b0;
    end
  end

  always_comb begin
    rd_value = '0;
    if (s1_command == CMD_READ) begin
      if (s1_sel == REG_MODULE) begin
        rd_value = DATA_WIDTH'({module_disable, 1'b0});
      end else begin
        for (int c = 0; c < CHANNELS; c++) begin
          if ({1'b0, s1_channel} == 3'(c)) begin
            rd_value = chan_rd[c];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      read_data   <= rd_value;
      irq_lines   <= irq_value;
      expired_now <= fired_value;
    end
  end

endmodule

`default_nettype wire
